// File: rtl/assert_macros.svh
// Assertion macros used by the port checker of the compass heading block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("compass heading check failed");

// Check that a condition in one cycle implies another in the next cycle.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("compass heading check failed");

`endif

// File: rtl/chms_pkg.sv
// Package for the compass heading motor selector: sizes, CORDIC angle table,
// register indexes, controller states and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package chms_pkg;

   // block configuration
   localparam int SAMPLES      = 8;
   localparam int MOTORS       = 14;
   localparam int CORDIC_STEPS = 20;

   // field widths
   localparam int FIELD_W    = 20;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int THRESH_W   = 15;
   localparam int BIN_W      = 4;
   localparam int HEAD_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // register reset values
   localparam int RST_INTERVAL  = 1000;
   localparam int RST_THRESHOLD = 1500;

   // burst accumulator and sample counter
   localparam int CNT_W = $clog2(SAMPLES + 1);
   localparam int SUM_W = FIELD_W + $clog2(SAMPLES);

   // exact division by SAMPLES through a scaled reciprocal
   localparam int     RECIP_SHIFT = SUM_W + 4;
   localparam int     RECIP_W     = RECIP_SHIFT + 1;
   localparam longint RECIP       = ((64'd1 << RECIP_SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam int     PROD_W      = SUM_W + RECIP_W;

   // CORDIC datapath
   localparam int CORR_W     = FIELD_W + 1;
   localparam int PRE_SHIFT  = 20;
   localparam int CW         = CORR_W + PRE_SHIFT + 3;
   localparam int ANG_W      = 32;
   localparam int ANG_FRAC   = 16;
   localparam int TAB_DEPTH  = 24;
   localparam int ITER_W     = $clog2(TAB_DEPTH);
   localparam int STEPS      = (CORDIC_STEPS < TAB_DEPTH) ? CORDIC_STEPS : TAB_DEPTH;
   localparam int HALF_ANGLE = 18000 * 65536;
   localparam int ROUND_HALF = 32768;

   // heading and motor bin
   localparam int FULL_CIRCLE = 36000;
   localparam int BIN_TOP     = 13;
   localparam int SCALED_W    = 20;
   localparam int WRAP_W      = HEAD_W + 1;

   // atan(2^-i) in centidegrees times 65536
   localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_DEPTH] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
      32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
      32'sd1466765,   32'sd733385,    32'sd366693,   32'sd183346,
      32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
      32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
      32'sd358,       32'sd179,       32'sd90,       32'sd45
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERVAL  = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_OFFSET_X  = 2'd2,
      CSR_OFFSET_Z  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_PREP,
      ST_ITER,
      ST_ROUND,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic accept;
      logic avg;
      logic prep;
      logic step;
      logic round;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic burst_done;
      logic iter_last;
      logic emit;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/chms_ctrl.sv
// Controller of the compass heading motor selector: sequences averaging,
// CORDIC iterations, rounding and the emit decision. Uses chms_pkg.
`timescale 1ns / 1ps

module chms_ctrl
   import chms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // advance through the burst-end sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.burst_done) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG:   state_in = ST_PREP;
         ST_PREP:  state_in = ST_ITER;
         ST_ITER: begin
            if (status.iter_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!status.emit || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // drive datapath commands
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.accept   = req_valid && (state_ff == ST_IDLE);
      cmd.avg      = (state_ff == ST_AVG);
      cmd.prep     = (state_ff == ST_PREP);
      cmd.step     = (state_ff == ST_ITER);
      cmd.round    = (state_ff == ST_ROUND);
      cmd.load_out = (state_ff == ST_DECIDE) && status.emit && status.out_free;
   end

endmodule

// File: rtl/chms_dpath.sv
// Datapath of the compass heading motor selector: configuration registers,
// burst sums, averaging, CORDIC, heading compare and output register. Uses chms_pkg.
`timescale 1ns / 1ps

module chms_dpath
   import chms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic signed [FIELD_W-1:0]  req_field_x,
   input  logic signed [FIELD_W-1:0]  req_field_z,
   input  logic [TIME_W-1:0]          req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BIN_W-1:0]           rsp_motor_bin,
   output logic [HEAD_W-1:0]          rsp_heading_centideg,
   input  ctrl_cmd_type               cmd,
   output dp_status_type              status
);

   // configuration
   logic [INTERVAL_W-1:0]      interval_ff;
   logic [THRESH_W-1:0]        thresh_ff;
   logic signed [FIELD_W-1:0]  offset_x_ff;
   logic signed [FIELD_W-1:0]  offset_z_ff;

   // burst state
   logic signed [SUM_W-1:0]    sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0]    sum_z_ff, sum_z_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       collecting_ff;
   logic [TIME_W-1:0]          now_ff;
   logic [TIME_W-1:0]          last_update_ff;
   logic [HEAD_W-1:0]          last_heading_ff;
   logic                       past;
   logic                       take;
   logic                       burst_done;
   logic [TIME_W:0]            deadline;

   // averaging
   logic [SUM_W-1:0]           mag_x, mag_z;
   logic [PROD_W-1:0]          prod_x, prod_z;
   logic [FIELD_W-1:0]         quo_x, quo_z;
   logic signed [FIELD_W-1:0]  avg_x_ff, avg_x_in;
   logic signed [FIELD_W-1:0]  avg_z_ff, avg_z_in;

   // CORDIC
   logic signed [CORR_W-1:0]   corr_x, corr_z;
   logic signed [CW-1:0]       px0, py0;
   logic signed [CW-1:0]       px_ff, px_in;
   logic signed [CW-1:0]       py_ff, py_in;
   logic signed [ANG_W-1:0]    ang_ff, ang_in;
   logic [ITER_W-1:0]          iter_ff;
   logic                       zero_ff;
   logic signed [CW-1:0]       dx, dy;
   logic                       iter_last;

   // rounding and decision
   logic signed [ANG_W-1:0]    ang_rnd;
   logic signed [ANG_W-1:0]    ang_sh;
   logic signed [WRAP_W-1:0]   r_raw;
   logic signed [WRAP_W-1:0]   r_wrap;
   logic [HEAD_W-1:0]          h_ff, h_in;
   logic [HEAD_W-1:0]          diff, alt, near_diff;
   logic                       emit;
   logic                       out_free;
   logic [SCALED_W-1:0]        scaled;
   logic [BIN_W-1:0]           quot;
   logic [BIN_W-1:0]           bin;

   // output register
   logic                       rsp_valid_ff;
   logic [BIN_W-1:0]           bin_ff;
   logic [HEAD_W-1:0]          head_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_W'(RST_INTERVAL);
         thresh_ff   <= THRESH_W'(RST_THRESHOLD);
         offset_x_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_INTERVAL:  interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_THRESHOLD: thresh_ff   <= csr_wdata[THRESH_W-1:0];
            CSR_OFFSET_X:  offset_x_ff <= csr_wdata[FIELD_W-1:0];
            CSR_OFFSET_Z:  offset_z_ff <= csr_wdata[FIELD_W-1:0];
            default:       ;
         endcase
      end
   end

   // gate samples on the update interval and accumulate the burst
   always_comb begin
      deadline   = {1'b0, last_update_ff} + (TIME_W + 1)'(interval_ff);
      past       = ({1'b0, req_now_ms} > deadline);
      take       = collecting_ff || past;
      sum_x_in   = (collecting_ff ? sum_x_ff : '0) + SUM_W'(req_field_x);
      sum_z_in   = (collecting_ff ? sum_z_ff : '0) + SUM_W'(req_field_z);
      cnt_in     = (collecting_ff ? cnt_ff : '0) + CNT_W'(1);
      burst_done = take && (cnt_in == CNT_W'(SAMPLES));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         cnt_ff        <= '0;
         sum_x_ff      <= '0;
         sum_z_ff      <= '0;
      end else if (cmd.accept && take) begin
         sum_x_ff <= sum_x_in;
         sum_z_ff <= sum_z_in;
         if (burst_done) begin
            collecting_ff <= 1'b0;
            cnt_ff        <= '0;
         end else begin
            collecting_ff <= 1'b1;
            cnt_ff        <= cnt_in;
         end
      end
   end

   // keep the time stamp of the burst's last beat
   always_ff @(posedge clock) begin
      if (cmd.accept && burst_done) begin
         now_ff <= req_now_ms;
      end
   end

   // divide the sums by SAMPLES toward zero
   always_comb begin
      mag_x    = sum_x_ff[SUM_W-1] ? SUM_W'(-sum_x_ff) : SUM_W'(sum_x_ff);
      mag_z    = sum_z_ff[SUM_W-1] ? SUM_W'(-sum_z_ff) : SUM_W'(sum_z_ff);
      prod_x   = PROD_W'(mag_x) * PROD_W'(RECIP);
      prod_z   = PROD_W'(mag_z) * PROD_W'(RECIP);
      quo_x    = FIELD_W'(prod_x >> RECIP_SHIFT);
      quo_z    = FIELD_W'(prod_z >> RECIP_SHIFT);
      avg_x_in = sum_x_ff[SUM_W-1] ? -$signed(quo_x) : $signed(quo_x);
      avg_z_in = sum_z_ff[SUM_W-1] ? -$signed(quo_z) : $signed(quo_z);
   end

   always_ff @(posedge clock) begin
      if (cmd.avg) begin
         avg_x_ff <= avg_x_in;
         avg_z_ff <= avg_z_in;
      end
   end

   // remove offsets and set up the vector, folding negative z by a half turn
   always_comb begin
      corr_x = CORR_W'(avg_x_ff) - CORR_W'(offset_x_ff);
      corr_z = CORR_W'(avg_z_ff) - CORR_W'(offset_z_ff);
      px0    = CW'(corr_z) <<< PRE_SHIFT;
      py0    = CW'(corr_x) <<< PRE_SHIFT;
      dx     = py_ff >>> iter_ff;
      dy     = px_ff >>> iter_ff;
      if (cmd.prep) begin
         if (corr_z < 0) begin
            px_in  = -px0;
            py_in  = -py0;
            ang_in = ANG_W'(HALF_ANGLE);
         end else begin
            px_in  = px0;
            py_in  = py0;
            ang_in = '0;
         end
      end else if (!py_ff[CW-1]) begin
         px_in  = px_ff + dx;
         py_in  = py_ff - dy;
         ang_in = ang_ff + ATAN_TAB[iter_ff];
      end else begin
         px_in  = px_ff - dx;
         py_in  = py_ff + dy;
         ang_in = ang_ff - ATAN_TAB[iter_ff];
      end
      iter_last = (iter_ff == ITER_W'(STEPS - 1));
   end

   // run one CORDIC step per cycle
   always_ff @(posedge clock) begin
      if (cmd.prep || cmd.step) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         ang_ff <= ang_in;
      end
      if (cmd.prep) begin
         iter_ff <= '0;
         zero_ff <= (corr_x == 0) && (corr_z == 0);
      end else if (cmd.step) begin
         iter_ff <= iter_ff + ITER_W'(1);
      end
   end

   // round to centidegrees and wrap into one turn
   always_comb begin
      ang_rnd = ang_ff + ANG_W'(ROUND_HALF);
      ang_sh  = ang_rnd >>> ANG_FRAC;
      r_raw   = WRAP_W'(ang_sh);
      if (r_raw < 0) begin
         r_wrap = r_raw + WRAP_W'(FULL_CIRCLE);
      end else if (r_raw >= WRAP_W'(FULL_CIRCLE)) begin
         r_wrap = r_raw - WRAP_W'(FULL_CIRCLE);
      end else begin
         r_wrap = r_raw;
      end
      h_in = zero_ff ? '0 : HEAD_W'(r_wrap);
   end

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         h_ff <= h_in;
      end
   end

   // compare with the last heading and pick the motor bin
   always_comb begin
      diff      = (h_ff >= last_heading_ff) ? (h_ff - last_heading_ff)
                                            : (last_heading_ff - h_ff);
      alt       = HEAD_W'(FULL_CIRCLE) - diff;
      near_diff = (alt < diff) ? alt : diff;
      emit      = (near_diff > HEAD_W'(thresh_ff));
      scaled    = SCALED_W'(h_ff) * SCALED_W'(MOTORS);
      quot      = '0;
      for (int k = 0; k < MOTORS; k++) begin
         quot = quot + {{(BIN_W - 1){1'b0}}, (scaled > SCALED_W'(FULL_CIRCLE * k))};
      end
      bin       = (quot >= BIN_W'(BIN_TOP)) ? '0 : (BIN_W'(BIN_TOP) - quot);
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // report status to the controller
   assign status = '{burst_done: burst_done, iter_last: iter_last,
                     emit: emit, out_free: out_free};

   // store the emitted heading and time
   always_ff @(posedge clock) begin
      if (reset) begin
         last_heading_ff <= '0;
         last_update_ff  <= '0;
      end else if (cmd.load_out) begin
         last_heading_ff <= h_ff;
         last_update_ff  <= now_ff;
      end
   end

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         bin_ff  <= bin;
         head_ff <= h_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_motor_bin        = bin_ff;
   assign rsp_heading_centideg = head_ff;

endmodule

// File: rtl/compass_heading_motor_selector_core.sv
// Sequence: a dropped beat or one that adds to a burst is taken while idle; the
// last beat of a burst runs averaging, set-up, the CORDIC steps (one per cycle),
// rounding and the emit decision; emits only if the heading change tops the threshold.
// Throughput: one beat per cycle inside a burst; a burst end holds the input for
// that sequence and while an earlier result beat still waits on the output.
// Reset: synchronous, clears state, sums and output valid; registers to defaults.
`timescale 1ns / 1ps

module compass_heading_motor_selector_core
   import chms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [FIELD_W-1:0]  req_field_x,
   input  logic signed [FIELD_W-1:0]  req_field_z,
   input  logic [TIME_W-1:0]          req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BIN_W-1:0]           rsp_motor_bin,
   output logic [HEAD_W-1:0]          rsp_heading_centideg
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequence the work
   chms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // compute the heading
   chms_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_field_x          (req_field_x),
      .req_field_z          (req_field_z),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_motor_bin        (rsp_motor_bin),
      .rsp_heading_centideg (rsp_heading_centideg),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

// File: rtl/chms_checker.sv
// Port-level checks for the compass heading motor selector result channel.
// Uses chms_pkg and assert_macros.svh; bound to the top level below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chms_checker
   import chms_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BIN_W-1:0]  rsp_motor_bin,
   input logic [HEAD_W-1:0] rsp_heading_centideg
);

   // hold a stalled result beat
   `CHK_NEXT(a_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_NEXT(a_payload_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_motor_bin) && $stable(rsp_heading_centideg))

   // heading within one turn and bin within the motor range
   `CHK_ALWAYS(a_range, clock, reset, !rsp_valid || ((rsp_heading_centideg < HEAD_W'(FULL_CIRCLE)) && (rsp_motor_bin <= BIN_W'(BIN_TOP))))

   // top bin exactly at zero heading
   `CHK_ALWAYS(a_top_bin, clock, reset, !rsp_valid || ((rsp_motor_bin == BIN_W'(BIN_TOP)) == (rsp_heading_centideg == '0)))

endmodule

bind compass_heading_motor_selector_core chms_checker u_chms_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_motor_bin        (rsp_motor_bin),
   .rsp_heading_centideg (rsp_heading_centideg)
);

// File: tb/compass_heading_motor_selector_checker.sv
// Checker for the compass heading motor selector: watches the register port and
// both handshake channels, predicts each result beat and compares it field by field.
// Depends on chms_pkg for port widths, burst size, motor count and CORDIC depth.
`timescale 1ns / 1ps

module compass_heading_motor_selector_checker
   import chms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [FIELD_W-1:0] req_field_x,
   input  logic signed [FIELD_W-1:0] req_field_z,
   input  logic [TIME_W-1:0]         req_now_ms,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [BIN_W-1:0]          rsp_motor_bin,
   input  logic [HEAD_W-1:0]         rsp_heading_centideg,
   output int                        error_count,
   output int                        pending_count
);

   // atan(2^-i) in centidegrees scaled by 2^16
   localparam longint ARCTAN_STEP [24] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466765, 733385, 366693, 183346,
      91673, 45837, 22918, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45
   };
   localparam int CIRCLE = 36000;

   typedef struct {
      logic [BIN_W-1:0]  bin;
      logic [HEAD_W-1:0] heading;
   } heading_beat_type;

   heading_beat_type due_beats [$];

   // register copies
   int          interval_ms;
   int          threshold;
   int          offset_x;
   int          offset_z;

   // burst and actuation state
   int          sum_x;
   int          sum_z;
   int          fill;
   bit          collecting;
   int          last_heading;
   logic [31:0] last_update_ms;

   task automatic report_mismatch(input string what);
      $display("%0t ERROR %s", $time, what);
      error_count++;
   endtask

   // vectoring CORDIC on the corrected field, result wrapped into one turn
   function automatic int cordic_heading(input longint xv, input longint zv);
      longint px, py, ang, dx, dy, r;
      if (xv == 0 && zv == 0)
         return 0;
      px = zv * 1048576;
      py = xv * 1048576;
      ang = 0;
      if (px < 0) begin
         px = -px;
         py = -py;
         ang = longint'(18000) * 65536;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px += dx;
            py -= dy;
            ang += ARCTAN_STEP[i];
         end else begin
            px -= dx;
            py += dy;
            ang -= ARCTAN_STEP[i];
         end
      end
      r = (ang + 32768) >>> 16;
      while (r < 0)
         r += CIRCLE;
      while (r >= CIRCLE)
         r -= CIRCLE;
      return int'(r);
   endfunction

   task automatic apply_register();
      case (csr_index_type'(csr_index))
         CSR_INTERVAL:  interval_ms = int'(csr_wdata[15:0]);
         CSR_THRESHOLD: threshold   = int'(csr_wdata[14:0]);
         CSR_OFFSET_X:  offset_x    = int'($signed(csr_wdata));
         CSR_OFFSET_Z:  offset_z    = int'($signed(csr_wdata));
         default: ;
      endcase
   endtask

   // fold one sample beat into the burst; queue a result when the heading moved enough
   task automatic absorb_sample();
      longint           ax, az;
      int               h, d, q;
      heading_beat_type beat;
      if (!collecting) begin
         if (64'(req_now_ms) <= 64'(last_update_ms) + 64'(interval_ms))
            return;
         collecting = 1'b1;
         sum_x = 0;
         sum_z = 0;
         fill = 0;
      end
      sum_x += req_field_x;
      sum_z += req_field_z;
      fill++;
      if (fill < SAMPLES)
         return;

      ax = longint'(sum_x / SAMPLES) - offset_x;
      az = longint'(sum_z / SAMPLES) - offset_z;
      collecting = 1'b0;
      sum_x = 0;
      sum_z = 0;
      fill = 0;

      h = cordic_heading(ax, az);
      d = (h >= last_heading) ? h - last_heading : last_heading - h;
      if (CIRCLE - d < d)
         d = CIRCLE - d;
      if (d <= threshold)
         return;

      q = (h * MOTORS + CIRCLE - 1) / CIRCLE;
      beat.bin = BIN_W'((q >= 13) ? 0 : 13 - q);
      beat.heading = HEAD_W'(h);
      last_update_ms = req_now_ms;
      last_heading = h;
      due_beats.push_back(beat);
   endtask

   task automatic check_beat();
      heading_beat_type want;
      if (due_beats.size() == 0) begin
         report_mismatch($sformatf("unexpected result beat: bin %0d heading %0d",
            rsp_motor_bin, rsp_heading_centideg));
         return;
      end
      want = due_beats.pop_front();
      if (rsp_motor_bin !== want.bin)
         report_mismatch($sformatf("motor_bin %0d, expected %0d (heading %0d)",
            rsp_motor_bin, want.bin, want.heading));
      if (rsp_heading_centideg !== want.heading)
         report_mismatch($sformatf("heading_centideg %0d, expected %0d",
            rsp_heading_centideg, want.heading));
   endtask

   // sample all channels at the edge where beats move
   always @(posedge clock) begin
      if (reset) begin
         interval_ms = RST_INTERVAL;
         threshold = RST_THRESHOLD;
         offset_x = 0;
         offset_z = 0;
         sum_x = 0;
         sum_z = 0;
         fill = 0;
         collecting = 1'b0;
         last_heading = 0;
         last_update_ms = '0;
         error_count = 0;
         due_beats.delete();
      end else begin
         if (csr_we)
            apply_register();
         if (req_valid && req_ready)
            absorb_sample();
         if (rsp_valid && rsp_ready)
            check_beat();
      end
      pending_count = due_beats.size();
   end

endmodule

// File: tb/compass_heading_motor_selector_core_test.sv
// Top of the compass heading motor selector test: clock, reset, sample and
// register stimulus with random idling, and the verdict.
// Depends on chms_pkg, the core and compass_heading_motor_selector_checker.
`timescale 1ns / 1ps

module compass_heading_motor_selector_core_test;
   import chms_pkg::*;

   localparam int     PERIOD      = 12;
   localparam int     PHASE_ITEMS = 240;
   localparam int     SETTLE      = CORDIC_STEPS + 16;
   localparam longint LIMIT_NS    = 64'd10_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [FIELD_W-1:0] req_field_x = '0;
   logic signed [FIELD_W-1:0] req_field_z = '0;
   logic [TIME_W-1:0]         req_now_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [BIN_W-1:0]          rsp_motor_bin;
   logic [HEAD_W-1:0]         rsp_heading_centideg;

   int     errors;
   int     pending;
   bit     steady = 1'b0;
   int     interval_ms = RST_INTERVAL;
   longint base_ms = 0;

   always #(PERIOD / 2) clock = ~clock;

   compass_heading_motor_selector_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_field_x          (req_field_x),
      .req_field_z          (req_field_z),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_motor_bin        (rsp_motor_bin),
      .rsp_heading_centideg (rsp_heading_centideg)
   );

   compass_heading_motor_selector_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_field_x          (req_field_x),
      .req_field_z          (req_field_z),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_motor_bin        (rsp_motor_bin),
      .rsp_heading_centideg (rsp_heading_centideg),
      .error_count          (errors),
      .pending_count        (pending)
   );

   // stall the result channel about 23 percent of the time outside the steady stretch
   always @(posedge clock)
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 23);

   function automatic int field_rand();
      logic [FIELD_W-1:0] raw;
      raw = FIELD_W'($urandom);
      return int'($signed(raw));
   endfunction

   function automatic int clamp_field(input int v);
      if (v > 524287)
         return 524287;
      if (v < -524288)
         return -524288;
      return v;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INTERVAL)
         interval_ms = int'(value[15:0]);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] interval, threshold, ox, oz);
      write_reg(CSR_INTERVAL, interval);
      write_reg(CSR_THRESHOLD, threshold);
      write_reg(CSR_OFFSET_X, ox);
      write_reg(CSR_OFFSET_Z, oz);
   endtask

   // idle at random, then hold the beat until it is taken
   task automatic push_sample(input int x, z, input logic [TIME_W-1:0] t);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(0, 99) < 23)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_field_x <= x[FIELD_W-1:0];
      req_field_z <= z[FIELD_W-1:0];
      req_now_ms <= t;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // drop valid, wait for every predicted beat, then let a suppressed burst finish
   task automatic await_quiet();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one full burst: the first beat is past the interval, inner time stamps are free
   task automatic send_burst(input int x0, z0, spread, input bit scatter, input int start_gap);
      longint t;
      int     x, z;
      for (int k = 0; k < SAMPLES; k++) begin
         if (scatter) begin
            x = field_rand();
            z = field_rand();
         end else begin
            x = clamp_field(x0 + int'($urandom_range(0, 2 * spread)) - spread);
            z = clamp_field(z0 + int'($urandom_range(0, 2 * spread)) - spread);
         end
         if (k == 0) begin
            t = base_ms + interval_ms + 1 + start_gap;
            base_ms = t;
         end else if (k == SAMPLES - 1) begin
            t = base_ms + $urandom_range(0, 20);
            base_ms = t;
         end else if (scatter || $urandom_range(0, 3) == 0) begin
            t = $urandom;
         end else begin
            t = base_ms + $urandom_range(0, 5);
         end
         push_sample(x, z, t[TIME_W-1:0]);
      end
   endtask

   // beats timed inside the interval while idle, so the block drops them
   task automatic send_drops(input int count);
      repeat (count)
         push_sample(field_rand(), field_rand(), $urandom_range(0, interval_ms));
   endtask

   task automatic run_random(input int target);
      int count;
      int pick;
      count = 0;
      while (count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_burst(field_rand(), field_rand(), $urandom_range(0, 64), 1'b0,
               $urandom_range(0, 40));
            count += SAMPLES;
         end else if (pick < 85) begin
            send_burst(0, 0, 0, 1'b1, $urandom_range(0, 40));
            count += SAMPLES;
         end else begin
            send_drops($urandom_range(1, 3));
         end
      end
   endtask

   initial begin
      #(LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes, the interval boundary, due east,
      // negative z only (half turn) and a zero vector that reads as north
      push_sample(-524288, 524287, 0);
      push_sample(524287, -524288, 1000);
      send_burst(524287, 0, 0, 1'b0, 0);
      send_burst(0, -524288, 0, 1'b0, 5);
      send_burst(0, 0, 0, 1'b0, 0);
      await_quiet();

      // random phases, each under its own settings
      for (int p = 0; p < 7; p++) begin
         steady = (p == 3);
         case (p)
            0: load_settings(0, 0, 0, 0);
            1: load_settings(65535, 18000, CSR_DATA_W'(-524288), 524287);
            2: load_settings(1000, 1500, 524287, CSR_DATA_W'(-524288));
            3: load_settings(CSR_DATA_W'($urandom_range(0, 5000)),
                  CSR_DATA_W'($urandom_range(0, 4000)),
                  CSR_DATA_W'(int'($urandom_range(0, 4000)) - 2000),
                  CSR_DATA_W'(int'($urandom_range(0, 4000)) - 2000));
            4: load_settings(37, 32767, 0, 0);
            5: load_settings(CSR_DATA_W'($urandom),
                  {5'($urandom), 15'($urandom_range(0, 4000))},
                  CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
            default: load_settings(250, 17999, 100, CSR_DATA_W'(-100));
         endcase
         run_random(PHASE_ITEMS);
         await_quiet();
      end
      steady = 1'b0;

      // late time stamps: the stored time plus the interval passes 32 bits,
      // so no later sample can start a burst
      load_settings(65535, 0, 0, 0);
      send_burst(524287, 0, 0, 1'b0, 0);
      base_ms = 64'hFFFF_0000 - interval_ms - 1;
      send_burst(-524288, 0, 0, 1'b0, 0);
      repeat (SAMPLES)
         push_sample(field_rand(), field_rand(), 32'hFFFF_FFFF);
      await_quiet();

      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
